[hdl/sha1_digest_engine_macros.svh]
// Assertion macros shared by the engine RTL.
// Each macro expects clk and rst in scope.
`ifndef SHA1_DIGEST_ENGINE_MACROS_SVH
`define SHA1_DIGEST_ENGINE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a property on every clock edge outside reset.
`define SHA1DE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition is followed by another in the next cycle.
`define SHA1DE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SHA1DE_ASSERT(lbl, prop, msg)
`define SHA1DE_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[hdl/sha1de_pkg.sv]
package sha1de_pkg;

  // Message length counter width (32..64)
  localparam int LENGTH_COUNTER_BITS = 64;

  // Request queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [6:0] LAST_ROUND  = 7'd79;
  localparam logic [4:0] LAST_DIGEST = 5'd19;
  localparam logic [7:0] PAD_MARK    = 8'h80;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  // Request classes after the front drops idle items
  typedef enum logic [1:0] {
    KIND_BYTE      = 2'd0,
    KIND_BYTE_LAST = 2'd1,
    KIND_END       = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } item_t;

  typedef enum logic [1:0] {
    ST_TAKE  = 2'd0,
    ST_PAD   = 2'd1,
    ST_ROUND = 2'd2,
    ST_ADD   = 2'd3
  } state_t;

  // Round constant by group of twenty rounds
  function automatic logic [31:0] round_k(input logic [1:0] grp);
    logic [31:0] k;
    case (grp)
      2'd0:    k = K0;
      2'd1:    k = K1;
      2'd2:    k = K2;
      default: k = K3;
    endcase
    return k;
  endfunction

  // Round function: choose, parity, majority, parity
  function automatic logic [31:0] round_f(input logic [1:0] grp, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (grp)
      2'd0:    f = (b & c) | (~b & d);
      2'd2:    f = (b & c) | (b & d) | (c & d);
      default: f = b ^ c ^ d;
    endcase
    return f;
  endfunction

endpackage

[hdl/sha1_digest_engine.sv]
// SHA-1 over a byte stream: one request per byte, 20 digest bytes per message.
// Intake shifts each queued byte into the block; a full 64-byte block then runs 80
// rounds and one chain update before intake or padding resumes.
// Digest bytes then leave one per cycle while out_ready is high.
// Reset: chain words to the initial hash, counters zero, 4-entry queue and output empty.
module sha1_digest_engine (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       is_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] digest_byte,
  output logic       digest_last
);

  sha1de_pkg::item_t push_item;
  sha1de_pkg::item_t head_item;
  logic              push;
  logic              q_full;
  logic              head_valid;
  logic              pop;

  sha1de_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .byte_valid (byte_valid),
    .is_last    (is_last),
    .q_full     (q_full),
    .push       (push),
    .push_item  (push_item)
  );

  sha1de_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  sha1de_core u_core (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (head_valid),
    .q_item      (head_item),
    .q_pop       (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_byte (digest_byte),
    .digest_last (digest_last)
  );

endmodule

[hdl/sha1de_front.sv]
module sha1de_front (
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  byte_valid,
  input  logic                  is_last,
  input  logic                  q_full,
  output logic                  push,
  output sha1de_pkg::item_t     push_item
);

  logic accept;

  // Take a request whenever the queue has room
  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Drop idle requests, queue everything else
  assign push = accept && (byte_valid || is_last);

  // Classify the request
  always_comb begin
    push_item.data = data_byte;
    if (byte_valid && is_last) begin
      push_item.kind = sha1de_pkg::KIND_BYTE_LAST;
    end else if (byte_valid) begin
      push_item.kind = sha1de_pkg::KIND_BYTE;
    end else begin
      push_item.kind = sha1de_pkg::KIND_END;
    end
  end

endmodule

[hdl/sha1de_queue.sv]
module sha1de_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sha1de_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output sha1de_pkg::item_t head_item
);

  sha1de_pkg::item_t                   entries [sha1de_pkg::Q_DEPTH];
  logic [sha1de_pkg::Q_PTR_W-1:0]      wr_ptr;
  logic [sha1de_pkg::Q_PTR_W-1:0]      rd_ptr;
  logic [sha1de_pkg::Q_CNT_W-1:0]      count;
  logic                                do_push;
  logic                                do_pop;

  localparam logic [sha1de_pkg::Q_PTR_W-1:0] PTR_LAST =
    sha1de_pkg::Q_PTR_W'(sha1de_pkg::Q_DEPTH - 1);
  localparam logic [sha1de_pkg::Q_CNT_W-1:0] CNT_FULL =
    sha1de_pkg::Q_CNT_W'(sha1de_pkg::Q_DEPTH);

  assign full       = (count == CNT_FULL);
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Hold queued requests
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

[hdl/sha1de_core.sv]
`include "sha1_digest_engine_macros.svh"

module sha1de_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  sha1de_pkg::item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        digest_byte,
  output logic              digest_last
);

  localparam int LCB = sha1de_pkg::LENGTH_COUNTER_BITS;

  sha1de_pkg::state_t state;
  sha1de_pkg::state_t state_next;

  logic [511:0]     blk;
  logic [31:0]      chain [5];
  logic [31:0]      sums  [5];
  logic [31:0]      wa, wb, wc, wd, we;
  logic [159:0]     dig;
  logic [LCB-1:0]   bit_count;
  logic [5:0]       pos;
  logic [6:0]       round_cnt;
  logic [4:0]       out_cnt;
  logic             pad_mode;
  logic             pad_first;
  logic             two_blk;
  logic             final_blk;

  logic             is_byte;
  logic             has_last;
  logic             blk_full;
  logic             shift_en;
  logic [7:0]       shift_byte;
  logic             start_cmp;
  logic             add_commit;
  logic             dig_load;
  logic             out_take;
  logic [7:0]       pad_byte;
  logic [63:0]      len64;
  logic [2:0]       len_idx;
  logic [1:0]       grp;
  logic [31:0]      w_new;
  logic [31:0]      temp;

  // Decode the queued request
  assign is_byte  = (q_item.kind inside {sha1de_pkg::KIND_BYTE, sha1de_pkg::KIND_BYTE_LAST});
  assign has_last = (q_item.kind inside {sha1de_pkg::KIND_BYTE_LAST, sha1de_pkg::KIND_END});
  assign blk_full = (pos == 6'd63);

  // Pick the padding byte: marker, zero fill or big-endian length
  assign len64   = 64'(bit_count);
  assign len_idx = 3'd7 - pos[2:0];
  always_comb begin
    if (pad_first) begin
      pad_byte = sha1de_pkg::PAD_MARK;
    end else if (pos[5:3] == 3'b111 && !two_blk) begin
      pad_byte = len64[{len_idx, 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Compute one round and the next schedule word
  always_comb begin
    if (round_cnt < 7'd20) begin
      grp = 2'd0;
    end else if (round_cnt < 7'd40) begin
      grp = 2'd1;
    end else if (round_cnt < 7'd60) begin
      grp = 2'd2;
    end else begin
      grp = 2'd3;
    end
  end
  assign w_new = {blk[95:64] ^ blk[255:224] ^ blk[447:416] ^ blk[511:480]}
                   << 1 | {31'd0, blk[95] ^ blk[255] ^ blk[447] ^ blk[511]};
  assign temp  = {wa[26:0], wa[31:27]} + sha1de_pkg::round_f(grp, wb, wc, wd) + we
                 + blk[511:480] + sha1de_pkg::round_k(grp);

  // Fold the working words into the chain
  assign sums[0] = chain[0] + wa;
  assign sums[1] = chain[1] + wb;
  assign sums[2] = chain[2] + wc;
  assign sums[3] = chain[3] + wd;
  assign sums[4] = chain[4] + we;

  assign out_take    = out_valid && out_ready;
  assign digest_byte = dig[159:152];
  assign digest_last = (out_cnt == sha1de_pkg::LAST_DIGEST);

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1de_pkg::ST_TAKE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence intake, padding, rounds, chain update and digest release
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    start_cmp  = 1'b0;
    add_commit = 1'b0;
    dig_load   = 1'b0;
    case (state)
      sha1de_pkg::ST_TAKE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (is_byte) begin
            shift_en   = 1'b1;
            shift_byte = q_item.data;
          end
          if (is_byte && blk_full) begin
            start_cmp  = 1'b1;
            state_next = sha1de_pkg::ST_ROUND;
          end else if (has_last) begin
            state_next = sha1de_pkg::ST_PAD;
          end
        end
      end
      sha1de_pkg::ST_PAD: begin
        shift_en   = 1'b1;
        shift_byte = pad_byte;
        if (blk_full) begin
          start_cmp  = 1'b1;
          state_next = sha1de_pkg::ST_ROUND;
        end
      end
      sha1de_pkg::ST_ROUND: begin
        if (round_cnt == sha1de_pkg::LAST_ROUND) begin
          state_next = sha1de_pkg::ST_ADD;
        end
      end
      sha1de_pkg::ST_ADD: begin
        if (!final_blk) begin
          add_commit = 1'b1;
          state_next = pad_mode ? sha1de_pkg::ST_PAD : sha1de_pkg::ST_TAKE;
        end else if (!out_valid) begin
          dig_load   = 1'b1;
          state_next = sha1de_pkg::ST_TAKE;
        end
      end
      default: begin
        state_next = sha1de_pkg::ST_TAKE;
      end
    endcase
  end

  // Update control state and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0]  <= sha1de_pkg::IV0;
      chain[1]  <= sha1de_pkg::IV1;
      chain[2]  <= sha1de_pkg::IV2;
      chain[3]  <= sha1de_pkg::IV3;
      chain[4]  <= sha1de_pkg::IV4;
      bit_count <= '0;
      pos       <= '0;
      round_cnt <= '0;
      pad_mode  <= 1'b0;
      pad_first <= 1'b0;
      two_blk   <= 1'b0;
      final_blk <= 1'b0;
      out_valid <= 1'b0;
      out_cnt   <= '0;
    end else begin
      if (shift_en) begin
        pos <= pos + 1'b1;
      end
      if (state == sha1de_pkg::ST_TAKE && q_pop) begin
        if (is_byte) begin
          bit_count <= bit_count + LCB'(8);
        end
        if (has_last) begin
          pad_mode  <= 1'b1;
          pad_first <= 1'b1;
        end
      end
      // Track which padded block is being filled
      if (state == sha1de_pkg::ST_PAD) begin
        pad_first <= 1'b0;
        if (blk_full) begin
          two_blk   <= 1'b0;
          final_blk <= !pad_first && !two_blk;
        end else if (pad_first) begin
          two_blk <= (pos[5:3] == 3'b111);
        end
      end
      if (state == sha1de_pkg::ST_ROUND) begin
        round_cnt <= (round_cnt == sha1de_pkg::LAST_ROUND) ? 7'd0 : round_cnt + 1'b1;
      end
      if (add_commit) begin
        for (int i = 0; i < 5; i++) begin
          chain[3'(i)] <= sums[3'(i)];
        end
      end
      // Release the digest and restart for the next message
      if (dig_load) begin
        chain[0]  <= sha1de_pkg::IV0;
        chain[1]  <= sha1de_pkg::IV1;
        chain[2]  <= sha1de_pkg::IV2;
        chain[3]  <= sha1de_pkg::IV3;
        chain[4]  <= sha1de_pkg::IV4;
        bit_count <= '0;
        pad_mode  <= 1'b0;
        final_blk <= 1'b0;
        out_valid <= 1'b1;
        out_cnt   <= '0;
      end else if (out_take) begin
        if (digest_last) begin
          out_valid <= 1'b0;
        end else begin
          out_cnt <= out_cnt + 1'b1;
        end
      end
    end
  end

  // Shift the block, run the working words, unload the digest
  always_ff @(posedge clk) begin
    if (shift_en) begin
      blk <= {blk[503:0], shift_byte};
    end else if (state == sha1de_pkg::ST_ROUND) begin
      blk <= {blk[479:0], w_new};
    end
    if (start_cmp) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
      we <= chain[4];
    end else if (state == sha1de_pkg::ST_ROUND) begin
      wa <= temp;
      wb <= wa;
      wc <= {wb[1:0], wb[31:2]};
      wd <= wc;
      we <= wd;
    end
    if (dig_load) begin
      dig <= {sums[0], sums[1], sums[2], sums[3], sums[4]};
    end else if (out_take) begin
      dig <= {dig[151:0], 8'h00};
    end
  end

  `SHA1DE_ASSERT(a_round_range, round_cnt <= sha1de_pkg::LAST_ROUND, "round count past 79")
  `SHA1DE_ASSERT_NEXT(a_round_to_add, state == sha1de_pkg::ST_ROUND && round_cnt == sha1de_pkg::LAST_ROUND, state == sha1de_pkg::ST_ADD, "missed chain update")
  `SHA1DE_ASSERT(a_out_cnt, out_valid |-> (out_cnt <= sha1de_pkg::LAST_DIGEST), "digest index out of range")
  `SHA1DE_ASSERT_NEXT(a_last_drop, out_valid && out_ready && digest_last, !out_valid, "digest not released")
  `SHA1DE_ASSERT(a_final_blk, final_blk |-> (pad_mode && !pad_first && !two_blk), "final block outside length block")

endmodule

[bench/sha1_digest_checker.sv]
`timescale 1ns / 100ps
module sha1_digest_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       byte_valid,
  input  logic       is_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] digest_byte,
  input  logic       digest_last,
  output int         outstanding,
  output int         errors
);

  localparam logic [31:0] RC0 = 32'h5A827999;
  localparam logic [31:0] RC1 = 32'h6ED9EBA1;
  localparam logic [31:0] RC2 = 32'h8F1BBCDC;
  localparam logic [31:0] RC3 = 32'hCA62C1D6;
  localparam logic [63:0] LEN_MASK =
    (64'd1 << sha1de_pkg::LENGTH_COUNTER_BITS) - 64'd1;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } digest_beat_t;

  // Digest bytes still owed by the engine, oldest first
  digest_beat_t digest_q[$];

  // Running hash state of the message in flight
  logic [31:0] chain_h [5];
  logic [7:0]  msg_block [64];
  logic [63:0] length_bits;
  logic [5:0]  fill_pos;

  initial begin
    errors      = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] digest mismatch: %s", $time, what);
    errors++;
  endtask

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void restart_message();
    chain_h[0]  = 32'h67452301;
    chain_h[1]  = 32'hEFCDAB89;
    chain_h[2]  = 32'h98BADCFE;
    chain_h[3]  = 32'h10325476;
    chain_h[4]  = 32'hC3D2E1F0;
    length_bits = '0;
    fill_pos    = '0;
  endfunction

  // Fold the current 64-byte block into the chaining words
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, t;
    for (int i = 0; i < 16; i++)
      w[4'(i)] = {msg_block[6'(4*i)], msg_block[6'(4*i+1)],
                  msg_block[6'(4*i+2)], msg_block[6'(4*i+3)]};
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    e = chain_h[4];
    for (int r = 0; r < 80; r++) begin
      // extend the schedule in place over a 16-word window
      if (r >= 16)
        w[4'(r)] = rol(w[4'(r+13)] ^ w[4'(r+8)] ^ w[4'(r+2)] ^ w[4'(r)], 1);
      case (r / 20)
        0: begin
          f = (b & c) | (~b & d);
          k = RC0;
        end
        1: begin
          f = b ^ c ^ d;
          k = RC1;
        end
        2: begin
          f = (b & c) | (b & d) | (c & d);
          k = RC2;
        end
        default: begin
          f = b ^ c ^ d;
          k = RC3;
        end
      endcase
      t = rol(a, 5) + f + e + k + w[4'(r)];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_h[0] += a;
    chain_h[1] += b;
    chain_h[2] += c;
    chain_h[3] += d;
    chain_h[4] += e;
  endfunction

  // Apply one request; on a message end queue the 20 digest bytes
  function automatic void absorb_request(input logic [7:0] d, input logic bv,
                                         input logic lst);
    digest_beat_t beat;
    int p;
    logic [63:0] len;
    if (bv) begin
      msg_block[fill_pos] = d;
      length_bits = (length_bits + 64'd8) & LEN_MASK;
      fill_pos++;
      if (fill_pos == 6'd0)
        sha1_compress();
    end
    if (!lst)
      return;
    // pad: marker, zero fill, then the bit length in the last 8 bytes
    p = int'(fill_pos);
    msg_block[6'(p)] = 8'h80;
    for (int i = p + 1; i < 64; i++)
      msg_block[6'(i)] = 8'h00;
    if (p >= 56) begin
      sha1_compress();
      for (int i = 0; i < 56; i++)
        msg_block[6'(i)] = 8'h00;
    end
    len = length_bits;
    for (int i = 0; i < 8; i++)
      msg_block[6'(63-i)] = len[6'(8*i) +: 8];
    sha1_compress();
    for (int i = 0; i < 20; i++) begin
      beat.value = chain_h[3'(i/4)][5'(24 - 8*(i%4)) +: 8];
      beat.last  = (i == 19);
      digest_q.push_back(beat);
    end
    restart_message();
  endfunction

  // Track requests, compare each digest byte with the oldest one owed
  always @(posedge clk) begin
    digest_beat_t want;
    if (rst) begin
      restart_message();
      digest_q.delete();
    end else begin
      if (in_valid && in_ready)
        absorb_request(data_byte, byte_valid, is_last);
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h with no digest pending", digest_byte));
        end else begin
          want = digest_q.pop_front();
          if (digest_byte !== want.value)
            report_mismatch($sformatf("digest_byte %02h, predicted %02h",
                                      digest_byte, want.value));
          if (digest_last !== want.last)
            report_mismatch($sformatf("digest_last %0b, predicted %0b",
                                      digest_last, want.last));
        end
      end
    end
    outstanding <= digest_q.size();
  end

endmodule

[bench/testbench.sv]
`timescale 1ns / 100ps
module testbench;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int LONG_HOLD     = 600;
  localparam int SETTLE_CYCLES = 400;
  localparam int RANDOM_ITEMS  = 70;

  typedef enum logic [1:0] {
    PH_DIRECTED,
    PH_PRESSURE,
    PH_RANDOM,
    PH_CALM
  } phase_t;

  logic       clk = 1'b0;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       is_last;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] digest_byte;
  logic       digest_last;

  int     outstanding;
  int     errors;
  int     cycle_count   = 0;
  int     requests_sent = 0;
  phase_t phase;

  always #6 clk = ~clk;

  sha1_digest_engine dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_byte (digest_byte),
    .digest_last (digest_last)
  );

  sha1_digest_checker digest_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .byte_valid  (byte_valid),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_byte (digest_byte),
    .digest_last (digest_last),
    .outstanding (outstanding),
    .errors      (errors)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one request, with an optional gap first; return once it is taken
  task automatic send_request(input logic [7:0] d, input logic bv, input logic lst);
    if (phase != PH_CALM && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= d;
    byte_valid <= bv;
    is_last    <= lst;
    do @(posedge clk); while (!in_ready);
    if (bv || lst)
      requests_sent++;
  endtask

  // Send a whole message with random content and some idle requests mixed in
  task automatic send_message(input int len);
    logic [7:0] d;
    bit         fold_last;
    fold_last = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      d = 8'($urandom_range(0, 255));
      send_request(d, 1'b1, fold_last && (i == len - 1));
    end
    if (!fold_last)
      send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Hold the input side until every owed digest byte has come out
  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly short messages, sometimes lengths near block boundaries
  function automatic int pick_length();
    int len;
    case ($urandom_range(0, 11))
      0:       len = 55;
      1:       len = 56;
      2:       len = 63;
      3:       len = 65;
      default: len = $urandom_range(0, 16);
    endcase
    return len;
  endfunction

  // Output side: random stalls, one long hold-off under pressure
  initial begin
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (phase == PH_PRESSURE && !long_hold_done) begin
        out_ready <= 1'b0;
        for (int n = 0; n < LONG_HOLD; n++) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (phase != PH_CALM && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int random_start;
    phase      <= PH_DIRECTED;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    data_byte  <= 8'h00;
    byte_valid <= 1'b0;
    is_last    <= 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message
    send_request(8'h5A, 1'b0, 1'b1);
    // "abc" with idle requests in between, last byte carries the end
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // extreme bytes, closed by a separate end marker
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hFF, 1'b0, 1'b1);
    // single byte messages
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    wait_drain();

    // fill the engine while the output is held off
    phase <= PH_PRESSURE;
    repeat (4) send_message($urandom_range(3, 6));
    wait_drain();

    // block-aligned message first, then random lengths
    phase <= PH_RANDOM;
    random_start = requests_sent;
    send_message(64);
    while (requests_sent - random_start < RANDOM_ITEMS)
      send_message(pick_length());

    // no idling on either side
    phase <= PH_CALM;
    send_message($urandom_range(0, 6));
    send_message($urandom_range(0, 6));
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

[sha1_digest_engine.f]
+incdir+hdl
hdl/sha1de_pkg.sv
hdl/sha1de_front.sv
hdl/sha1de_queue.sv
hdl/sha1de_core.sv
hdl/sha1_digest_engine.sv
bench/sha1_digest_checker.sv
bench/testbench.sv
